[rtl/fsds_pkg.sv]
// Shared types and fixed field widths for the data stack core.
package fsds_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PeekW   = 4;
  localparam int unsigned DepthOW = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    OP_PUSH    = 3'd0,
    OP_DISCARD = 3'd1,
    OP_SWAP    = 3'd2,
    OP_OVER    = 3'd3,
    OP_ROT     = 3'd4,
    OP_MAX     = 3'd5,
    OP_MIN     = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

endpackage

[rtl/forth_style_data_stack_core.sv]
// Bounded LIFO data stack of signed words, one operation per transaction.
// Takes one transaction per clock cycle: a transaction is accepted when start is high and busy
// is low, and its result appears on the result ports in the next cycle for exactly one cycle,
// marked by done_o. Busy is high during reset and until ready_q is set once reset is released.
// The top three elements live in registers and the rest in a single-write memory. Push, over
// and the pops (discard, max, min) move one word between the register window and the memory.
// Rejected operations (status underflow or overflow) leave the stack unchanged.
module forth_style_data_stack_core #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [fsds_pkg::ModeW-1:0]          mode_i,
  input  logic signed [fsds_pkg::ValueW-1:0]  push_value_i,
  input  logic [fsds_pkg::PeekW-1:0]          peek_position_i,
  output logic                                done_o,
  output logic signed [fsds_pkg::ValueW-1:0]  top_value_o,
  output logic signed [fsds_pkg::ValueW-1:0]  peek_value_o,
  output logic [fsds_pkg::DepthOW-1:0]        stack_depth_o,
  output logic [fsds_pkg::StatusW-1:0]        status_o
);
  import fsds_pkg::*;

  localparam int unsigned DCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = (DCW > PeekW) ? DCW : PeekW;
  localparam logic [DCW-1:0] Full = DCW'(STACK_DEPTH);

  logic                  ready_q, valid_q;
  logic [DCW-1:0]        depth_q, depth_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] r0_q, r1_q, r2_q, r0_d, r1_d, r2_d;
  logic [PeekW-1:0]      peek_q;
  logic [DATA_WIDTH-1:0] stack_mem_q [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] fill_q, peek_mem_q;

  logic                  accept;
  op_e                   op;
  logic [DATA_WIDTH-1:0] push_word, best;
  logic                  a_big, spill_en;
  logic [AW-1:0]         spill_addr, fill_addr, peek_addr;
  logic [CW-1:0]         depth_ext, peek_ext;

  assign busy      = ~ready_q;
  assign accept    = start & ready_q;
  assign op        = op_e'(mode_i);
  assign push_word = DATA_WIDTH'(push_value_i);
  assign a_big     = $signed(r0_q) > $signed(r1_q);
  assign best      = ((op == OP_MAX) == a_big) ? r0_q : r1_q;

  always_comb begin
    depth_d    = depth_q;
    status_d   = ST_OK;
    r0_d       = r0_q;
    r1_d       = r1_q;
    r2_d       = r2_q;
    spill_en   = 1'b0;
    if (accept) begin
      unique case (op)
        OP_PUSH: begin
          if (depth_q == Full) begin
            status_d = ST_OVERFLOW;
          end else begin
            r0_d     = push_word;
            r1_d     = r0_q;
            r2_d     = r1_q;
            spill_en = depth_q >= DCW'(3);
            depth_d  = depth_q + DCW'(1);
          end
        end
        OP_DISCARD: begin
          if (depth_q < DCW'(1)) begin
            status_d = ST_UNDERFLOW;
          end else begin
            r0_d    = r1_q;
            r1_d    = r2_q;
            r2_d    = fill_q;
            depth_d = depth_q - DCW'(1);
          end
        end
        OP_SWAP: begin
          if (depth_q < DCW'(2)) begin
            status_d = ST_UNDERFLOW;
          end else begin
            r0_d = r1_q;
            r1_d = r0_q;
          end
        end
        OP_OVER: begin
          if (depth_q < DCW'(2)) begin
            status_d = ST_UNDERFLOW;
          end else if (depth_q == Full) begin
            status_d = ST_OVERFLOW;
          end else begin
            r0_d     = r1_q;
            r1_d     = r0_q;
            r2_d     = r1_q;
            spill_en = depth_q >= DCW'(3);
            depth_d  = depth_q + DCW'(1);
          end
        end
        OP_ROT: begin
          if (depth_q < DCW'(3)) begin
            status_d = ST_UNDERFLOW;
          end else begin
            r0_d = r2_q;
            r1_d = r0_q;
            r2_d = r1_q;
          end
        end
        OP_MAX, OP_MIN: begin
          if (depth_q < DCW'(2)) begin
            status_d = ST_UNDERFLOW;
          end else begin
            r0_d    = best;
            r1_d    = r2_q;
            r2_d    = fill_q;
            depth_d = depth_q - DCW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry i of the stack sits at memory address i while it is below the register window.
  assign depth_ext  = CW'(depth_d);
  assign peek_ext   = CW'(peek_position_i);
  assign spill_addr = AW'(depth_q - DCW'(3));
  assign fill_addr  = AW'(depth_ext - CW'(4));
  assign peek_addr  = AW'(depth_ext - CW'(1) - peek_ext);

  // Read ports forward the spill written at the same edge.
  always_ff @(posedge clk_i) begin
    if (spill_en) begin
      stack_mem_q[spill_addr] <= r2_q;
    end
    fill_q     <= (spill_en && spill_addr == fill_addr) ? r2_q : stack_mem_q[fill_addr];
    peek_mem_q <= (spill_en && spill_addr == peek_addr) ? r2_q : stack_mem_q[peek_addr];
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
    r2_q <= r2_d;
    if (accept) begin
      peek_q <= peek_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q  <= 1'b0;
      valid_q  <= 1'b0;
      depth_q  <= '0;
      status_q <= ST_OK;
    end else begin
      ready_q  <= 1'b1;
      valid_q  <= accept;
      depth_q  <= depth_d;
      status_q <= status_d;
    end
  end

  logic [DATA_WIDTH-1:0] peek_word;

  always_comb begin
    priority if (CW'(peek_q) >= CW'(depth_q)) begin
      peek_word = '0;
    end else if (peek_q == PeekW'(0)) begin
      peek_word = r0_q;
    end else if (peek_q == PeekW'(1)) begin
      peek_word = r1_q;
    end else if (peek_q == PeekW'(2)) begin
      peek_word = r2_q;
    end else begin
      peek_word = peek_mem_q;
    end
  end

  assign done_o        = valid_q;
  assign top_value_o   = (depth_q == '0) ? '0 : ValueW'(r0_q);
  assign peek_value_o  = ValueW'(peek_word);
  assign stack_depth_o = DepthOW'(depth_q);
  assign status_o      = status_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted transaction produced no result");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= Full)
    else $error("stack depth beyond capacity");

  a_reject_holds_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q != ST_OK) |-> depth_q == $past(depth_q))
    else $error("rejected operation changed depth");

  a_overflow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == ST_OVERFLOW) |-> $past(depth_q) == Full)
    else $error("overflow reported below capacity");

  a_underflow_when_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == ST_UNDERFLOW) |-> $past(depth_q) < DCW'(3))
    else $error("underflow reported with three or more elements");

endmodule

[tb/sv/forth_style_data_stack_core_test.sv]
// Self-checking testbench for the data stack core: directed and random operation streams.
module forth_style_data_stack_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fsds_pkg::*;

  localparam int unsigned StackSize  = 16;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainWait  = 6;

  // Mode code that the block treats as a no-operation.
  localparam logic [ModeW-1:0] ModeUnused = 3'd7;

  localparam int unsigned RegimeFill   = 0;
  localparam int unsigned RegimeGrow   = 1;
  localparam int unsigned RegimeShrink = 2;
  localparam int unsigned RegimeMixed  = 3;

  typedef struct {
    logic [ModeW-1:0]         mode;
    logic signed [ValueW-1:0] value;
    logic [PeekW-1:0]         peek;
  } stack_op_t;

  typedef struct {
    logic signed [ValueW-1:0] top;
    logic signed [ValueW-1:0] peeked;
    logic [DepthOW-1:0]       depth;
    status_e                  status;
  } stack_result_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     start           = 1'b0;
  logic [ModeW-1:0]         mode_i          = '0;
  logic signed [ValueW-1:0] push_value_i    = '0;
  logic [PeekW-1:0]         peek_position_i = '0;
  logic                     busy;
  logic                     done_o;
  logic signed [ValueW-1:0] top_value_o;
  logic signed [ValueW-1:0] peek_value_o;
  logic [DepthOW-1:0]       stack_depth_o;
  logic [StatusW-1:0]       status_o;

  stack_op_t     pending_ops[$];
  stack_result_t expected_results[$];

  // Shadow copy of the stack contents
  logic signed [ValueW-1:0] shadow_words[StackSize];
  int unsigned              shadow_depth = 0;

  bit          took_op         = 1'b0;
  int unsigned ops_in_flight   = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned underflow_seen  = 0;
  int unsigned overflow_seen   = 0;
  int unsigned full_seen       = 0;

  forth_style_data_stack_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .push_value_i   (push_value_i),
    .peek_position_i(peek_position_i),
    .done_o         (done_o),
    .top_value_o    (top_value_o),
    .peek_value_o   (peek_value_o),
    .stack_depth_o  (stack_depth_o),
    .status_o       (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one operation to the shadow stack and return the result it should produce.
  function automatic stack_result_t apply_stack_op(stack_op_t op);
    stack_result_t            res;
    logic signed [ValueW-1:0] held;
    int unsigned              d;
    d = shadow_depth;
    res.status = ST_OK;
    case (op.mode)
      OP_PUSH: begin
        if (d >= StackSize) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_words[d] = op.value;
          shadow_depth = d + 1;
        end
      end
      OP_DISCARD: begin
        if (d < 1) res.status = ST_UNDERFLOW;
        else shadow_depth = d - 1;
      end
      OP_SWAP: begin
        if (d < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          held = shadow_words[d-1];
          shadow_words[d-1] = shadow_words[d-2];
          shadow_words[d-2] = held;
        end
      end
      OP_OVER: begin
        if (d < 2) begin
          res.status = ST_UNDERFLOW;
        end else if (d >= StackSize) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_words[d] = shadow_words[d-2];
          shadow_depth = d + 1;
        end
      end
      OP_ROT: begin
        if (d < 3) begin
          res.status = ST_UNDERFLOW;
        end else begin
          held = shadow_words[d-3];
          shadow_words[d-3] = shadow_words[d-2];
          shadow_words[d-2] = shadow_words[d-1];
          shadow_words[d-1] = held;
        end
      end
      OP_MAX, OP_MIN: begin
        if (d < 2) begin
          res.status = ST_UNDERFLOW;
        end else begin
          // Keep the larger (max) or smaller (min) of the top two, signed.
          if ((shadow_words[d-1] > shadow_words[d-2]) == (op.mode == OP_MAX))
            shadow_words[d-2] = shadow_words[d-1];
          shadow_depth = d - 1;
        end
      end
      default: ;
    endcase
    res.top    = (shadow_depth == 0) ? '0 : shadow_words[shadow_depth-1];
    res.peeked = (op.peek < shadow_depth) ? shadow_words[shadow_depth-1-op.peek] : '0;
    res.depth  = DepthOW'(shadow_depth);
    return res;
  endfunction

  // Driver: hold a transaction until it is taken, otherwise launch the next or idle.
  always @(negedge clk_i) begin
    stack_op_t nxt;
    if (!(start && !took_op)) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_ops[0];
        pending_ops.delete(0);
        ops_in_flight++;
        start           <= 1'b1;
        mode_i          <= nxt.mode;
        push_value_i    <= nxt.value;
        peek_position_i <= nxt.peek;
      end else begin
        start           <= 1'b0;
        mode_i          <= ModeW'($urandom);
        push_value_i    <= $urandom;
        peek_position_i <= PeekW'($urandom);
      end
    end
  end

  // Monitor: check the result of the previous transaction, then predict the one taken now.
  always @(posedge clk_i) begin
    stack_op_t     op;
    stack_result_t exp;
    if (!rst_ni) begin
      took_op = 1'b0;
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result top %0d peek %0d depth %0d status %0d",
                   $time, top_value_o, peek_value_o, stack_depth_o, status_o);
          error_count++;
        end else begin
          exp = expected_results[0];
          expected_results.delete(0);
          results_checked++;
          if (ops_in_flight != 0) ops_in_flight--;
          if (top_value_o !== exp.top) begin
            $display("%0t: top_value expected %0d actual %0d", $time, exp.top, top_value_o);
            error_count++;
          end
          if (peek_value_o !== exp.peeked) begin
            $display("%0t: peek_value expected %0d actual %0d",
                     $time, exp.peeked, peek_value_o);
            error_count++;
          end
          if (stack_depth_o !== exp.depth) begin
            $display("%0t: stack_depth expected %0d actual %0d",
                     $time, exp.depth, stack_depth_o);
            error_count++;
          end
          if (status_o !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, status_o);
            error_count++;
          end
          if (exp.status == ST_UNDERFLOW) underflow_seen++;
          if (exp.status == ST_OVERFLOW) overflow_seen++;
          if (exp.depth == StackSize) full_seen++;
        end
      end
      took_op = start && !busy;
      if (took_op) begin
        op.mode  = mode_i;
        op.value = push_value_i;
        op.peek  = peek_position_i;
        expected_results.push_back(apply_stack_op(op));
      end
    end
  end

  task automatic add_op(logic [ModeW-1:0] mode, logic signed [ValueW-1:0] value,
                        logic [PeekW-1:0] peek);
    stack_op_t op;
    op.mode  = mode;
    op.value = value;
    op.peek  = peek;
    pending_ops.push_back(op);
  endtask

  // Queue operations in runs that push the stack towards full, towards empty, or leave it be.
  task automatic queue_random_ops(int unsigned count);
    int unsigned              mode_cdf[4][8] = '{
      '{60, 62, 70, 90, 95, 97, 99, 100},
      '{40, 50, 60, 72, 82, 89, 96, 100},
      '{12, 42, 50, 55, 63, 80, 97, 100},
      '{20, 34, 48, 60, 72, 84, 96, 100}
    };
    logic signed [ValueW-1:0] corner_values[5] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh1
    };
    int unsigned              left, run, regime, pick, idx;
    logic signed [ValueW-1:0] value;
    left = count;
    while (left != 0) begin
      regime = $urandom_range(RegimeFill, RegimeMixed);
      run = $urandom_range(12, 40);
      if (run > left) run = left;
      left -= run;
      repeat (run) begin
        pick = $urandom_range(0, 99);
        idx = 0;
        while (pick >= mode_cdf[regime][idx]) idx++;
        pick = $urandom_range(0, 99);
        if (pick < 8) value = corner_values[$urandom_range(0, 4)];
        else if (pick < 35) value = $urandom_range(0, 16) - 8;
        else value = $urandom;
        add_op(ModeW'(idx), value,
               ($urandom_range(0, 2) == 0) ? PeekW'($urandom_range(0, 3))
                                           : PeekW'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || ops_in_flight != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 35;
    // Rejections on an empty stack, then signed extremes through every operation.
    add_op(OP_DISCARD, 32'sh0, 4'd0);
    add_op(OP_SWAP, 32'sh0, 4'd1);
    add_op(OP_OVER, 32'sh0, 4'd0);
    add_op(OP_ROT, 32'sh0, 4'd2);
    add_op(OP_MAX, 32'sh0, 4'd0);
    add_op(OP_MIN, 32'sh0, 4'd0);
    add_op(ModeUnused, 32'sh7FFF_FFFF, 4'd15);
    add_op(OP_PUSH, 32'sh8000_0000, 4'd0);
    add_op(OP_SWAP, 32'sh0, 4'd0);
    add_op(OP_PUSH, 32'sh7FFF_FFFF, 4'd1);
    add_op(OP_ROT, 32'sh0, 4'd1);
    add_op(OP_MAX, 32'sh0, 4'd0);
    add_op(OP_PUSH, 32'sh8000_0000, 4'd1);
    add_op(OP_MIN, 32'sh0, 4'd0);
    add_op(OP_PUSH, -32'sh1, 4'd2);
    add_op(OP_PUSH, 32'sh0, 4'd3);
    add_op(OP_OVER, 32'sh0, 4'd3);
    add_op(OP_ROT, 32'sh0, 4'd2);
    add_op(OP_SWAP, 32'sh0, 4'd1);
    add_op(ModeUnused, 32'sh0, 4'd0);
    add_op(OP_MAX, 32'sh0, 4'd1);
    add_op(OP_DISCARD, 32'sh0, 4'd15);
    queue_random_ops(380);
    wait_until_drained();

    send_idle_pct = 72;
    queue_random_ops(380);
    wait_until_drained();

    send_idle_pct = 0;
    queue_random_ops(390);
    wait_until_drained();

    // Allow for a late or stray result before the verdict.
    repeat (DrainWait) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("Checked %0d results across three idle settings and a directed opening;",
             results_checked);
    $display("saw %0d underflow and %0d overflow rejections, stack full %0d times, %0d errors",
             underflow_seen, overflow_seen, full_seen, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run stopped after %0d cycles with %0d operations outstanding",
             $time, cycles, ops_in_flight + pending_ops.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/fsds_pkg.sv
rtl/forth_style_data_stack_core.sv
tb/sv/forth_style_data_stack_core_test.sv
